/* src/vna_pkg.sv */
// Shared constants and types for the vertex normal accumulator.
package vna_pkg;

	localparam int NUM_VERTICES_DEF = 4096;
	localparam int ACC_WIDTH_DEF    = 24;
	localparam int IDX_W            = 12;
	localparam int COORD_W          = 32;
	localparam int NORM_W           = 16;
	localparam int UNIT_ONE         = 16384;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_TRI  = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]                 op;
		logic [IDX_W-1:0]           first_index;
		logic [IDX_W-1:0]           second_index;
		logic [IDX_W-1:0]           third_index;
		logic signed [COORD_W-1:0]  coord_x;
		logic signed [COORD_W-1:0]  coord_y;
		logic signed [COORD_W-1:0]  coord_z;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]          vertex_id;
		logic signed [NORM_W-1:0]  normal_x;
		logic signed [NORM_W-1:0]  normal_y;
		logic signed [NORM_W-1:0]  normal_z;
		logic                      zero_normal;
	} rsp_t;

endpackage

/* src/vna_stream_if.sv */
// Valid/ready channel carrying one payload type.
interface vna_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* src/vna_norm_unit.sv */
// Multi-cycle normalizer: integer square root and three rounded divisions to Q2.14.
module vna_norm_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [32:0]  vec_x,
	input  logic signed [32:0]  vec_y,
	input  logic signed [32:0]  vec_z,
	output logic                done,
	output logic                nonzero,
	output logic signed [15:0]  unit_x,
	output logic signed [15:0]  unit_y,
	output logic signed [15:0]  unit_z
);
	typedef enum logic [2:0] {S_IDLE, S_SQ, S_SUM, S_SQRT, S_DIV, S_DONE} state_t;

	state_t            state_q;
	logic [31:0]       mag_q [3];
	logic [2:0]        neg_q;
	logic [63:0]       sq_q [3];
	logic [32:0]       root_q;
	logic [5:0]        cnt_q;
	logic [1:0]        lane_q;
	logic [46:0]       dnum_q;
	logic [32:0]       drem_q;
	logic [15:0]       quo_q;
	logic [15:0]       res_q [3];

	logic [33:0] dtrial;
	logic [46:0] num_w;
	logic [31:0] mag_sel;

	always_comb begin
		mag_sel  = mag_q[lane_q];
		num_w    = {1'b0, mag_sel, 14'd0} + {15'd0, root_q[32:1]};
		dtrial   = {drem_q, dnum_q[46]} - {1'b0, root_q};
	end

	// restoring square root over 33 digit pairs: radicand kept in sum register
	logic [66:0] sr_rem_q;
	logic [66:0] sr_rem_n;
	logic [66:0] sr_try;
	logic [65:0] sr_src_q;
	always_comb begin
		sr_rem_n = {sr_rem_q[64:0], sr_src_q[65:64]};
		sr_try   = {32'd0, root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						mag_q[0] <= 32'(vec_x < 0 ? -vec_x : vec_x);
						mag_q[1] <= 32'(vec_y < 0 ? -vec_y : vec_y);
						mag_q[2] <= 32'(vec_z < 0 ? -vec_z : vec_z);
						neg_q    <= {vec_z[32], vec_y[32], vec_x[32]};
						state_q  <= S_SQ;
					end
				end
				S_SQ: begin
					for (int i = 0; i < 3; i++) sq_q[i] <= 64'(mag_q[i]) * 64'(mag_q[i]);
					state_q <= S_SUM;
				end
				S_SUM: begin
					sr_src_q <= 66'(sq_q[0]) + 66'(sq_q[1]) + 66'(sq_q[2]);
					sr_rem_q <= '0;
					root_q   <= '0;
					cnt_q    <= 6'd33;
					state_q  <= S_SQRT;
				end
				S_SQRT: begin
					sr_src_q <= {sr_src_q[63:0], 2'b00};
					if (sr_rem_n >= sr_try) begin
						sr_rem_q <= sr_rem_n - sr_try;
						root_q   <= {root_q[31:0], 1'b1};
					end else begin
						sr_rem_q <= sr_rem_n;
						root_q   <= {root_q[31:0], 1'b0};
					end
					// last step leaves the count at zero for the first divide
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						lane_q  <= 2'd0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (root_q == '0) begin
						nonzero <= 1'b0;
						unit_x  <= '0;
						unit_y  <= '0;
						unit_z  <= '0;
						state_q <= S_DONE;
					end else if (cnt_q == 6'd0) begin
						dnum_q <= num_w;
						drem_q <= '0;
						quo_q  <= '0;
						cnt_q  <= 6'd47;
					end else begin
						dnum_q <= {dnum_q[45:0], 1'b0};
						if (!dtrial[33]) begin
							drem_q <= dtrial[32:0];
							quo_q  <= {quo_q[14:0], 1'b1};
						end else begin
							drem_q <= {drem_q[31:0], dnum_q[46]};
							quo_q  <= {quo_q[14:0], 1'b0};
						end
						cnt_q <= cnt_q - 6'd1;
						if (cnt_q == 6'd1) begin
							res_q[lane_q] <= dtrial[33] ? {quo_q[14:0], 1'b0}
							                           : {quo_q[14:0], 1'b1};
							if (lane_q == 2'd2) begin
								nonzero <= 1'b1;
								state_q <= S_DONE;
							end
							lane_q <= lane_q + 2'd1;
						end
					end
				end
				S_DONE: begin
					if (nonzero) begin
						unit_x <= neg_q[0] ? -$signed(res_q[0]) : $signed(res_q[0]);
						unit_y <= neg_q[1] ? -$signed(res_q[1]) : $signed(res_q[1]);
						unit_z <= neg_q[2] ? -$signed(res_q[2]) : $signed(res_q[2]);
					end
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* src/vertex_normal_accumulate_core.sv */
// Top level: vertex position and normal accumulator memories with a sequencer.
//
// Items are handled one at a time. A load is written to the position memory when it is
// accepted. A triangle reads its three corner positions over the single memory read port,
// scales the edges down, forms the cross product and scales it into 32 bits, then
// normalizes it in a shared unit (33 square-root steps plus three divisions) and, if the
// normal is nonzero, writes three accumulators back through read-modify-write; a read
// fetches one accumulator, normalizes it the same way and then waits for the response
// slot to be free. After reset the accumulator memory is cleared, one entry a cycle,
// before the first request is taken.
module vertex_normal_accumulate_core #(
	parameter int NUM_VERTICES = vna_pkg::NUM_VERTICES_DEF,
	parameter int ACC_WIDTH    = vna_pkg::ACC_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	vna_stream_if.sink   req,
	vna_stream_if.source rsp
);
	localparam int AW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
	localparam int CW = vna_pkg::COORD_W;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RD0, S_RD1, S_RD2, S_EDGE, S_SHIFT, S_MUL, S_CROSS,
		S_CSHIFT, S_NORM, S_ACC_RD, S_ACC_WR, S_OUT
	} state_t;

	state_t state_q;
	logic [CW-1:0] pos_x_mem [NUM_VERTICES];
	logic [CW-1:0] pos_y_mem [NUM_VERTICES];
	logic [CW-1:0] pos_z_mem [NUM_VERTICES];
	logic [3*ACC_WIDTH-1:0] acc_mem [NUM_VERTICES];

	logic [AW-1:0]            prd_addr;
	logic signed [CW-1:0]     prd_x, prd_y, prd_z;
	logic [AW-1:0]            ard_addr;
	logic [3*ACC_WIDTH-1:0]   ard_data;
	logic                     awr_en;
	logic [AW-1:0]            awr_addr;
	logic [3*ACC_WIDTH-1:0]   awr_data;

	vna_pkg::req_t   req_q;
	logic [AW:0]     clr_q;
	logic [1:0]      corner_q;
	logic signed [CW-1:0] p0_q [3];
	logic signed [CW-1:0] p1_q [3];
	logic signed [32:0] e_q [6];
	logic [1:0]         esh_q;
	logic signed [63:0] m_q [6];
	logic signed [63:0] c_q [3];
	logic               ns_start_q;
	logic               ns_done, ns_nz;
	logic signed [15:0] ns_x, ns_y, ns_z;
	logic signed [32:0] nv_q [3];
	logic signed [15:0] un_q [3];
	logic               nz_q;
	logic               is_read_q;
	vna_pkg::rsp_t      rsp_q;
	logic               rsp_valid_q;
	logic               rsp_load;

	// position memory: one write, one read port
	always_ff @(posedge clk) begin
		if (req.valid && req.ready && req.payload.op == vna_pkg::OP_LOAD &&
		    32'(req.payload.first_index) < 32'(NUM_VERTICES)) begin
			pos_x_mem[AW'(req.payload.first_index)] <= req.payload.coord_x;
			pos_y_mem[AW'(req.payload.first_index)] <= req.payload.coord_y;
			pos_z_mem[AW'(req.payload.first_index)] <= req.payload.coord_z;
		end
		prd_x <= pos_x_mem[prd_addr];
		prd_y <= pos_y_mem[prd_addr];
		prd_z <= pos_z_mem[prd_addr];
	end

	// accumulator memory: one write, one read port
	always_ff @(posedge clk) begin
		if (awr_en) acc_mem[awr_addr] <= awr_data;
		ard_data <= acc_mem[ard_addr];
	end

	function automatic logic [AW-1:0] corner(vna_pkg::req_t r, logic [1:0] k);
		case (k)
			2'd0:    corner = AW'(r.first_index);
			2'd1:    corner = AW'(r.second_index);
			default: corner = AW'(r.third_index);
		endcase
	endfunction

	assign prd_addr = corner(req_q, corner_q);
	assign ard_addr = corner(req_q, corner_q);

	logic signed [ACC_WIDTH-1:0] acc_cur [3];
	logic signed [ACC_WIDTH-1:0] acc_new [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [ACC_WIDTH:0] s;
			acc_cur[i] = ard_data[i*ACC_WIDTH +: ACC_WIDTH];
			s = (ACC_WIDTH+1)'(acc_cur[i]) + (ACC_WIDTH+1)'(un_q[i]);
			if (s[ACC_WIDTH] != s[ACC_WIDTH-1])
				acc_new[i] = s[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
				                          : {1'b0, {(ACC_WIDTH-1){1'b1}}};
			else
				acc_new[i] = s[ACC_WIDTH-1:0];
		end
	end

	always_comb begin
		awr_en   = 1'b0;
		awr_addr = corner(req_q, corner_q);
		awr_data = {acc_new[2], acc_new[1], acc_new[0]};
		if (state_q == S_CLEAR) begin
			awr_en   = 1'b1;
			awr_addr = clr_q[AW-1:0];
			awr_data = '0;
		end else if (state_q == S_ACC_WR) begin
			awr_en = 1'b1;
		end
	end

	logic e_fit, c_fit;
	always_comb begin
		e_fit = 1'b1;
		for (int i = 0; i < 6; i++)
			if (e_q[i] < -33'sd1073741824 || e_q[i] > 33'sd1073741823) e_fit = 1'b0;
		c_fit = 1'b1;
		for (int i = 0; i < 3; i++)
			if (c_q[i] < -64'sd2147483648 || c_q[i] > 64'sd2147483647) c_fit = 1'b0;
	end

	logic idx_ok;
	assign idx_ok = 32'(req_q.first_index) < 32'(NUM_VERTICES) &&
	                32'(req_q.second_index) < 32'(NUM_VERTICES) &&
	                32'(req_q.third_index) < 32'(NUM_VERTICES);

	vna_norm_unit u_norm (
		.clk(clk), .arst_n(arst_n), .start(ns_start_q),
		.vec_x(nv_q[0]), .vec_y(nv_q[1]), .vec_z(nv_q[2]),
		.done(ns_done), .nonzero(ns_nz),
		.unit_x(ns_x), .unit_y(ns_y), .unit_z(ns_z)
	);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// a new response only goes out once the previous one has left
	assign rsp_load = (state_q == S_OUT) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
			ns_start_q  <= 1'b0;
		end else begin
			ns_start_q  <= 1'b0;
			rsp_valid_q <= rsp_load || (rsp_valid_q && !rsp.ready);
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == NUM_VERTICES - 1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req.valid) begin
						req_q    <= req.payload;
						corner_q <= 2'd0;
						case (req.payload.op)
							vna_pkg::OP_TRI:  state_q <= S_RD0;
							vna_pkg::OP_READ: state_q <= S_RD0;
							default:          state_q <= S_IDLE;
						endcase
						is_read_q <= (req.payload.op == vna_pkg::OP_READ);
					end
				end
				S_RD0: begin
					if (is_read_q) begin
						if (32'(req_q.first_index) >= 32'(NUM_VERTICES)) begin
							nv_q[0] <= '0; nv_q[1] <= '0; nv_q[2] <= '0;
							ns_start_q <= 1'b1;
							state_q <= S_NORM;
						end else state_q <= S_RD1;
					end else if (!idx_ok) state_q <= S_IDLE;
					else begin
						corner_q <= 2'd1;
						state_q  <= S_RD1;
					end
				end
				S_RD1: begin
					if (is_read_q) begin
						for (int i = 0; i < 3; i++)
							nv_q[i] <= 33'($signed(ard_data[i*ACC_WIDTH +: ACC_WIDTH]));
						ns_start_q <= 1'b1;
						state_q <= S_NORM;
					end else begin
						p0_q[0] <= prd_x; p0_q[1] <= prd_y; p0_q[2] <= prd_z;
						corner_q <= 2'd2;
						state_q  <= S_RD2;
					end
				end
				S_RD2: begin
					p1_q[0] <= prd_x; p1_q[1] <= prd_y; p1_q[2] <= prd_z;
					state_q <= S_EDGE;
				end
				S_EDGE: begin
					e_q[0] <= 33'(p1_q[0]) - 33'(p0_q[0]);
					e_q[1] <= 33'(p1_q[1]) - 33'(p0_q[1]);
					e_q[2] <= 33'(p1_q[2]) - 33'(p0_q[2]);
					e_q[3] <= 33'(prd_x) - 33'(p0_q[0]);
					e_q[4] <= 33'(prd_y) - 33'(p0_q[1]);
					e_q[5] <= 33'(prd_z) - 33'(p0_q[2]);
					esh_q   <= '0;
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if (!e_fit && esh_q != 2'd3) begin
						for (int i = 0; i < 6; i++) e_q[i] <= e_q[i] >>> 1;
						esh_q <= esh_q + 2'd1;
					end else state_q <= S_MUL;
				end
				S_MUL: begin
					// shifted edges fit in 31 bits
					m_q[0] <= 64'(e_q[1]) * 64'(e_q[5]);
					m_q[1] <= 64'(e_q[2]) * 64'(e_q[4]);
					m_q[2] <= 64'(e_q[2]) * 64'(e_q[3]);
					m_q[3] <= 64'(e_q[0]) * 64'(e_q[5]);
					m_q[4] <= 64'(e_q[0]) * 64'(e_q[4]);
					m_q[5] <= 64'(e_q[1]) * 64'(e_q[3]);
					state_q <= S_CROSS;
				end
				S_CROSS: begin
					c_q[0] <= m_q[0] - m_q[1];
					c_q[1] <= m_q[2] - m_q[3];
					c_q[2] <= m_q[4] - m_q[5];
					state_q <= S_CSHIFT;
				end
				S_CSHIFT: begin
					if (!c_fit) begin
						for (int i = 0; i < 3; i++) c_q[i] <= c_q[i] >>> 1;
					end else begin
						for (int i = 0; i < 3; i++) nv_q[i] <= 33'(c_q[i]);
						ns_start_q <= 1'b1;
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (ns_done) begin
						un_q[0] <= ns_x; un_q[1] <= ns_y; un_q[2] <= ns_z;
						nz_q    <= ns_nz;
						if (is_read_q) state_q <= S_OUT;
						else if (!ns_nz) state_q <= S_IDLE;
						else begin
							corner_q <= 2'd0;
							state_q  <= S_ACC_RD;
						end
					end
				end
				S_ACC_RD: state_q <= S_ACC_WR;
				S_ACC_WR: begin
					// read data is registered; next corner reads after this write lands
					if (corner_q == 2'd2) state_q <= S_IDLE;
					else begin
						corner_q <= corner_q + 2'd1;
						state_q  <= S_ACC_RD;
					end
				end
				S_OUT: begin
					if (rsp_load) begin
						rsp_q.vertex_id   <= req_q.first_index;
						rsp_q.normal_x    <= un_q[0];
						rsp_q.normal_y    <= un_q[1];
						rsp_q.normal_z    <= un_q[2];
						rsp_q.zero_normal <= !nz_q;
						state_q           <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ast_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !req.ready)
		else $error("request taken during clear");
	ast_one_write_per_corner: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ACC_WR |-> $past(state_q) == S_ACC_RD)
		else $error("accumulator write without read");
	ast_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
		else $error("response dropped");
endmodule
